// ===== hw/rtl/m3h_pkg.sv =====
// Shared constants, datapath command codes and status types of the stream hash block.
`default_nettype none
package m3h_pkg;

  localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2  = 32'h1b873593;
  localparam logic [31:0] MUR_ADD = 32'he6546b64;
  localparam logic [31:0] MUR_F1  = 32'h85ebca6b;
  localparam logic [31:0] MUR_F2  = 32'hc2b2ae35;

  localparam int unsigned CFG_AW = 3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_K_C1,
    OP_K_C2,
    OP_FOLD,
    OP_TAIL_C1,
    OP_FIN_MIX,
    OP_AV_F1,
    OP_AV_F2,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_next;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/m3h_cfg.sv =====
// APB-style configuration register file holding the seed.
`default_nettype none
module m3h_cfg
  import m3h_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [31:0]       seed
);

  logic [31:0] seed_r;
  logic [31:0] seed_nxt;
  logic        sel_seed;

  assign sel_seed = (paddr[CFG_AW-1] == 1'b0);
  assign pready   = 1'b1;
  assign prdata   = sel_seed ? seed_r : 32'h0;
  assign seed     = seed_r;

  always_comb begin
    seed_nxt = seed_r;
    if (psel && penable && pwrite && pready && sel_seed) begin
      seed_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'h0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/m3h_dp.sv =====
// Datapath: block gathering, shared multiplier, running hash, length count and finalizer.
`default_nettype none
module m3h_dp
  import m3h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic [31:0] seed,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  output logic      [31:0] out_hash_value
);

  logic [31:0] hash_r, hash_nxt;
  logic [23:0] part_r, part_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] res_r, res_nxt;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_p;
  logic [31:0] h_start;
  logic [31:0] fold_x;
  logic [31:0] fin_x;
  logic [31:0] k_rot15;
  logic [31:0] k_sh13;

  assign k_rot15 = {k_r[16:0], k_r[31:17]};
  assign k_sh13  = k_r ^ {13'h0, k_r[31:13]};
  assign h_start = (len_r == 64'h0) ? seed : hash_r;
  assign fold_x  = hash_r ^ k_r;
  assign fin_x   = hash_r ^ k_r ^ len_r[31:0] ^ len_r[63:32];
  assign mul_p   = mul_a * mul_b;

  assign sts.blk_next  = in_has_byte && (len_r[1:0] == 2'd3);
  assign out_hash_value = res_r;

  always_comb begin
    mul_a = k_r;
    mul_b = MUR_C1;
    case (cmd.op)
      OP_K_C2: begin
        mul_a = k_rot15;
        mul_b = MUR_C2;
      end
      OP_TAIL_C1: begin
        mul_a = {8'h0, part_r};
        mul_b = MUR_C1;
      end
      OP_AV_F1: begin
        mul_a = k_r;
        mul_b = MUR_F1;
      end
      OP_AV_F2: begin
        mul_a = k_sh13;
        mul_b = MUR_F2;
      end
      default: begin
        mul_a = k_r;
        mul_b = MUR_C1;
      end
    endcase
  end

  always_comb begin
    hash_nxt = hash_r;
    part_nxt = part_r;
    len_nxt  = len_r;
    k_nxt    = k_r;
    res_nxt  = res_r;
    case (cmd.op)
      OP_ACCEPT: begin
        hash_nxt = h_start;
        if (in_has_byte) begin
          len_nxt = len_r + 64'd1;
          case (len_r[1:0])
            2'd0: part_nxt = {part_r[23:8], in_data_byte};
            2'd1: part_nxt = {part_r[23:16], in_data_byte, part_r[7:0]};
            2'd2: part_nxt = {in_data_byte, part_r[15:0]};
            default: begin
              k_nxt    = {in_data_byte, part_r};
              part_nxt = 24'h0;
            end
          endcase
        end
      end
      OP_K_C1, OP_K_C2, OP_TAIL_C1, OP_AV_F1, OP_AV_F2: begin
        k_nxt = mul_p;
      end
      OP_FOLD: begin
        hash_nxt = {fold_x[18:0], fold_x[31:19]} + {fold_x[16:0], fold_x[31:19], 2'b00}
                   + MUR_ADD;
      end
      OP_FIN_MIX: begin
        k_nxt = fin_x ^ {16'h0, fin_x[31:16]};
      end
      OP_EMIT: begin
        res_nxt  = k_r ^ {16'h0, k_r[31:16]};
        hash_nxt = seed;
        part_nxt = 24'h0;
        len_nxt  = 64'h0;
      end
      default: begin
        hash_nxt = hash_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= 32'h0;
      part_r <= 24'h0;
      len_r  <= 64'h0;
    end else begin
      hash_r <= hash_nxt;
      part_r <= part_nxt;
      len_r  <= len_nxt;
    end
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/m3h_ctrl.sv =====
// Controller state machine sequencing block mixing, finalization and the result handshake.
`default_nettype none
module m3h_ctrl
  import m3h_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_has_byte,
  input  wire logic in_last,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLK_C1,
    S_BLK_C2,
    S_BLK_FOLD,
    S_TL_C1,
    S_TL_C2,
    S_FIN_MIX,
    S_AV_F1,
    S_AV_F2,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit_go;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign emit_go   = !out_valid_r || out_ready;

  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE:     cmd.op = accept ? OP_ACCEPT : OP_NONE;
      S_BLK_C1:   cmd.op = OP_K_C1;
      S_BLK_C2:   cmd.op = OP_K_C2;
      S_BLK_FOLD: cmd.op = OP_FOLD;
      S_TL_C1:    cmd.op = OP_TAIL_C1;
      S_TL_C2:    cmd.op = OP_K_C2;
      S_FIN_MIX:  cmd.op = OP_FIN_MIX;
      S_AV_F1:    cmd.op = OP_AV_F1;
      S_AV_F2:    cmd.op = OP_AV_F2;
      S_EMIT:     cmd.op = emit_go ? OP_EMIT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_last;
          if (sts.blk_next && in_has_byte) begin
            state_nxt = S_BLK_C1;
          end else if (in_last) begin
            state_nxt = S_TL_C1;
          end
        end
      end
      S_BLK_C1:   state_nxt = S_BLK_C2;
      S_BLK_C2:   state_nxt = S_BLK_FOLD;
      S_BLK_FOLD: state_nxt = last_r ? S_TL_C1 : S_IDLE;
      S_TL_C1:    state_nxt = S_TL_C2;
      S_TL_C2:    state_nxt = S_FIN_MIX;
      S_FIN_MIX:  state_nxt = S_AV_F1;
      S_AV_F1:    state_nxt = S_AV_F2;
      S_AV_F2:    state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/murmur3_32_stream_hash_top.sv =====
// A byte that does not complete a block is taken in the idle state; one that completes it also runs
// the block C1, C2 and fold states. A last request adds tail mixing and finalization on the shared
// multiplier, and the emit state loads the hash into the output register once the prior result is
// taken; the result then waits for out_ready. One request per cycle is taken within a block, with
// in_ready low outside idle. Reset (synchronous, active low) clears seed, state and output valid.
`default_nettype none
module murmur3_32_stream_hash_top
  import m3h_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_has_byte,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [31:0]       out_hash_value,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [31:0] seed;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  m3h_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed    (seed)
  );

  m3h_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_has_byte (in_has_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  m3h_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .seed           (seed),
    .in_data_byte   (in_data_byte),
    .in_has_byte    (in_has_byte),
    .out_hash_value (out_hash_value)
  );

endmodule
`default_nettype wire
